>>> rtl/core/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared codes, character constants and helper types for the integer to
// ASCII text core.
// ----------------------------------------------------------------------------
package ita_pkg;

  // Operation codes; the unused code falls through to unsigned decimal
  localparam logic [1:0] OP_SIGNED   = 2'd0;
  localparam logic [1:0] OP_UNSIGNED = 2'd1;
  localparam logic [1:0] OP_HEX      = 2'd2;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;

  // Upper bound on characters per number
  localparam int RESULT_LIMIT = 20;
  localparam int CHAR_CNT_W   = $clog2(RESULT_LIMIT + 1);

  typedef struct packed {
    logic start;
    logic hex;
  } ita_conv_req_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic hex;
  } ita_emit_req_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = 8'h37 + {4'd0, d};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/ita_conv.sv
// ----------------------------------------------------------------------------
// ita_conv
// Bit-serial shift-add-3 converter: one magnitude bit enters per cycle, the
// digit cells correct and shift in parallel; hex mode skips the correction.
// ----------------------------------------------------------------------------
module ita_conv #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ita_pkg::ita_conv_req_t               req,
  input  logic [VALUE_BITS-1:0]                mag,
  output logic                                 done,
  output logic [3:0]                           digits [MAX_DIGITS],
  output logic [$clog2(MAX_DIGITS+1)-1:0]      count
);
  import ita_pkg::*;

  localparam int BW = $clog2(VALUE_BITS + 1);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic                  hex_r;
  logic [BW-1:0]         bits_r;
  logic [VALUE_BITS-1:0] shreg_r;
  logic [3:0]            dig_r   [MAX_DIGITS];
  logic [3:0]            corr    [MAX_DIGITS];
  logic [3:0]            dig_nxt [MAX_DIGITS];
  logic                  carry   [MAX_DIGITS];
  logic [CW-1:0]         cnt_r;
  logic                  grow;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (!hex_r && dig_r[i] >= 4'd5) begin
        corr[i] = dig_r[i] + 4'd3;
      end else begin
        corr[i] = dig_r[i];
      end
    end
    carry[0] = shreg_r[VALUE_BITS-1];
    for (int i = 1; i < MAX_DIGITS; i++) begin
      carry[i] = corr[i-1][3];
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig_nxt[i] = {corr[i][2:0], carry[i]};
    end
    // a one moving into the first unused digit makes it significant
    grow = (cnt_r == '0) ? shreg_r[VALUE_BITS-1] : 1'b0;
    for (int i = 0; i < MAX_DIGITS - 1; i++) begin
      if (cnt_r == CW'(i + 1)) begin
        grow = corr[i][3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bits_r <= '0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        bits_r <= BW'(VALUE_BITS);
        cnt_r  <= '0;
      end else if (busy_r) begin
        bits_r <= bits_r - 1'b1;
        if (grow) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (bits_r == BW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hex_r   <= req.hex;
      shreg_r <= mag;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig_r[i] <= 4'd0;
      end
    end else if (busy_r) begin
      shreg_r <= {shreg_r[VALUE_BITS-2:0], 1'b0};
      for (int i = 0; i < MAX_DIGITS; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
    end
  end

  assign done   = done_r;
  assign digits = dig_r;
  assign count  = cnt_r;

endmodule

>>> rtl/core/ita_emit.sv
// ----------------------------------------------------------------------------
// ita_emit
// Character sequencer: sign, hex prefix, then digits from the most
// significant down, into a registered output stage.
// ----------------------------------------------------------------------------
module ita_emit #(
  parameter int MAX_DIGITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ita_pkg::ita_emit_req_t          req,
  input  logic [3:0]                      digits [MAX_DIGITS],
  input  logic [$clog2(MAX_DIGITS+1)-1:0] count,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  output logic                            out_tlast,
  output logic                            finish
);
  import ita_pkg::*;

  localparam int IW = $clog2(MAX_DIGITS);
  localparam int CW = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MINUS = 3'd1;
  localparam logic [2:0] ST_ZERO  = 3'd2;
  localparam logic [2:0] ST_X     = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  logic [IW-1:0]         idx_r;
  logic [CHAR_CNT_W-1:0] nch_r;
  logic                  valid_r;
  logic [7:0]            data_r;
  logic                  last_r;
  logic [CW-1:0]         ndig;
  logic                  adv;
  logic                  load;
  logic                  fin;
  logic                  lim;
  logic [7:0]            ch;

  assign ndig = (count == '0) ? CW'(1) : count;
  assign adv  = !valid_r || out_tready;
  assign load = adv && (state_r != ST_IDLE);
  assign lim  = (nch_r == CHAR_CNT_W'(RESULT_LIMIT - 1));

  always_comb begin
    ch        = CHAR_ZERO;
    fin       = lim;
    state_nxt = ST_IDLE;
    case (state_r)
      ST_MINUS: begin
        ch        = CHAR_MINUS;
        state_nxt = ST_DIGIT;
      end
      ST_ZERO: begin
        ch        = CHAR_ZERO;
        state_nxt = ST_X;
      end
      ST_X: begin
        ch        = CHAR_X;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        ch        = digit_char(digits[idx_r]);
        fin       = lim || (idx_r == '0);
        state_nxt = ST_DIGIT;
      end
      default: begin
        fin       = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      nch_r   <= '0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
      if (req.start) begin
        nch_r <= '0;
        idx_r <= IW'(ndig - 1'b1);
        if (req.neg) begin
          state_r <= ST_MINUS;
        end else if (req.hex) begin
          state_r <= ST_ZERO;
        end else begin
          state_r <= ST_DIGIT;
        end
      end else if (load) begin
        nch_r   <= nch_r + 1'b1;
        state_r <= fin ? ST_IDLE : state_nxt;
        if (state_r == ST_DIGIT) begin
          idx_r <= idx_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= ch;
      last_r <= fin;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign finish     = load && fin;

endmodule

>>> rtl/core/integer_to_ascii_text_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_text_core
// Formats one integer as ASCII text: signed or unsigned decimal, or 0x hex.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one number per transfer (operation code and
//   value). The output stream returns its text one character per transfer,
//   most significant first, with out_tlast on the final character.
//   Signed decimal leads with '-' for negative values; hex leads with "0x"
//   and drops leading zeros; zero gives a single '0' digit.
// Sequence and throughput:
//   The converter shifts one value bit per cycle through the digit cells,
//   starting on acceptance. Its done flag, the sequencer state and the
//   output register lie between the last bit and the first character; then
//   one character per cycle follows while the receiver keeps out_tready high.
//   The next number is taken once the final character sits in the output register.
// Reset and stalls:
//   Synchronous active-low reset returns to idle with nothing pending.
//   While out_tready is low the current character is held and the sequencer
//   waits; no character is lost or repeated.
// ----------------------------------------------------------------------------
module integer_to_ascii_text_core #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [1:0] operation, [65:2] value, [71:66] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast
);
  import ita_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic                  busy_r;
  logic                  neg_r;
  logic                  hex_r;
  logic                  accept;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] val;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  ita_conv_req_t         conv_req;
  ita_emit_req_t         emit_req;
  logic                  conv_done;
  logic [3:0]            digits [MAX_DIGITS];
  logic [CW-1:0]         count;
  logic                  finish;

  // One number in flight: take a new one only once the last character is loaded into the output register
  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;

  // Keep only the low VALUE_BITS; negate two's complement for negative signed input
  assign op  = in_tdata[1:0];
  assign val = in_tdata[VALUE_BITS+1:2];
  assign neg = (op == OP_SIGNED) && val[VALUE_BITS-1];
  assign mag = neg ? (~val + 1'b1) : val;

  assign conv_req.start = accept;
  assign conv_req.hex   = (op == OP_HEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (finish) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= neg;
      hex_r <= (op == OP_HEX);
    end
  end

  ita_conv #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (conv_req),
    .mag    (mag),
    .done   (conv_done),
    .digits (digits),
    .count  (count)
  );

  // Start emission as soon as the last bit has passed the digit cells
  assign emit_req.start = conv_done;
  assign emit_req.neg   = neg_r;
  assign emit_req.hex   = hex_r;

  ita_emit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (emit_req),
    .digits     (digits),
    .count      (count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .finish     (finish)
  );

endmodule

>>> tb/integer_to_ascii_text_core_test.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_text_core_test
// Self-checking bench for the integer to ASCII text core. Numbers go into the
// input stream with random gaps. A local formatter predicts the characters
// of each accepted number, and a monitor compares every output transfer with
// the oldest predicted character while the receiver stalls at random.
// ----------------------------------------------------------------------------
module integer_to_ascii_text_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  // Operation code that the core treats as unsigned decimal
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int  DIGIT_SLOTS   = 20;
  localparam int  MAX_GAP       = 19;
  localparam int  RANDOM_ITEMS  = 237;
  localparam int  DRAIN_CYCLES  = 120;
  localparam longint CYCLE_LIMIT = 1_000_000;

  // One predicted output transfer
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // [1:0] operation, [65:2] value, [71:66] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] character
  logic        out_tlast;

  text_char_t  pending_text[$];   // characters still owed by the core
  int          error_count   = 0;
  int          chars_checked = 0;
  int          numbers_sent  = 0;
  int          numbers_by_op[4] = '{0, 0, 0, 0};
  bit          back_to_back  = 1'b0;  // suppress gaps and stalls on both sides
  int          stall_left    = 0;
  longint      cycle_count   = 0;

  integer_to_ascii_text_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still owed",
               cycle_count, pending_text.size());
      $display("FAIL");
      $finish;
    end
  end

  // Draw a wait in cycles; none while running back to back
  function automatic int draw_wait();
    if (back_to_back) return 0;
    // favor short waits so long texts still see runs of consecutive transfers
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Format one number the way the core should and queue its characters
  function automatic void queue_number_text(input logic [1:0] op, input logic [63:0] value);
    logic [63:0] magnitude;
    logic [63:0] radix;
    logic [3:0]  digits[DIGIT_SLOTS];
    int          digit_total;
    logic        negative;
    logic [7:0]  text[$];
    text_char_t  entry;
    magnitude   = value;
    negative    = 1'b0;
    digit_total = 0;
    // two's complement only for signed decimal; the most negative value
    // negates to itself, which reads correctly as an unsigned magnitude
    if (op == OP_SIGNED && value[63]) begin
      negative  = 1'b1;
      magnitude = -value;
    end
    radix = (op == OP_HEX) ? 64'd16 : 64'd10;
    // extract digits least significant first
    do begin
      if (digit_total < DIGIT_SLOTS) begin
        digits[digit_total] = 4'(magnitude % radix);
        digit_total++;
      end
      magnitude = magnitude / radix;
    end while (magnitude != 64'd0);
    if (negative) text.push_back(CHAR_MINUS);
    if (op == OP_HEX) begin
      text.push_back(CHAR_ZERO);
      text.push_back(CHAR_X);
    end
    // emit most significant first, upper-case letters for hex
    for (int k = digit_total - 1; k >= 0; k--) begin
      if (digits[k] < 4'd10) text.push_back(8'("0") + 8'(digits[k]));
      else text.push_back(8'("A") + 8'(digits[k]) - 8'd10);
    end
    foreach (text[i]) begin
      entry.character = text[i];
      entry.last      = (i == text.size() - 1);
      pending_text.push_back(entry);
    end
  endfunction

  // Present one number and hold it until the core takes it
  task automatic send_number(input logic [1:0] op, input logic [63:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // a zero gap keeps in_tvalid high straight into the next transfer
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, value, op};
    do @(posedge clk); while (!in_tready);
    queue_number_text(op, value);
    numbers_sent++;
    numbers_by_op[op]++;
  endtask

  // Output monitor: check each transfer, then pick the next stall
  always @(posedge clk) begin
    text_char_t want;
    int         stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected character: got %h last %b", out_tdata, out_tlast);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (out_tdata !== want.character) begin
          $error("character: expected %h actual %h", want.character, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_tlast);
          error_count++;
        end
      end
      chars_checked++;
      stall = draw_wait();
      stall_left <= stall;
      out_tready <= (stall == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Zero in every operation, including the unused code, and small values at the digit boundaries
  task automatic test_zero_and_small();
    for (int op = 0; op < 4; op++) send_number(2'(op), 64'd0);
    send_number(OP_SIGNED, 64'd9);
    send_number(OP_UNSIGNED, 64'd10);
    send_number(OP_HEX, 64'd15);
    send_number(OP_HEX, 64'd16);
  endtask

  // Sign handling at the edges of the signed range
  task automatic test_signed_extremes();
    send_number(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);          // -1
    send_number(OP_SIGNED, 64'h8000_0000_0000_0000);          // most negative
    send_number(OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF);          // most positive
    send_number(OP_SIGNED, -64'd10);
  endtask

  // Full-width unsigned values and the twenty-digit boundary
  task automatic test_unsigned_extremes();
    send_number(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(OP_UNSIGNED, 64'd10_000_000_000_000_000_000);
    send_number(OP_UNSIGNED, 64'd9_999_999_999_999_999_999);
    send_number(OP_UNSIGNED, 64'h8000_0000_0000_0000);
  endtask

  // Every hex digit, leading-zero suppression, full width
  task automatic test_hex_digits();
    send_number(OP_HEX, 64'h0123_4567_89AB_CDEF);
    send_number(OP_HEX, 64'hFEDC_BA98_7654_3210);
    send_number(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(OP_HEX, 64'h0000_0000_0000_0A00);
  endtask

  // Unused code formats as unsigned decimal, never signed
  task automatic test_unused_operation();
    send_number(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(OP_UNUSED, 64'd12345);
    send_number(OP_UNUSED, 64'h8000_0000_0000_0000);
  endtask

  // Random numbers with a spread of magnitudes; run back to back in spells
  task automatic test_random_numbers();
    logic [1:0]  op;
    logic [63:0] value;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      back_to_back = (n % 80) >= 60;
      op    = 2'($urandom_range(0, 3));
      value = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: value = value >> $urandom_range(0, 63);               // short value
        1: value = -(value >> $urandom_range(0, 63));            // negated short value
        2: value = 64'd0;
        3: value = 64'd1 << $urandom_range(0, 63);
        4: value = ~(64'd0) >> $urandom_range(0, 63);
        default: ;                                                // full width
      endcase
      send_number(op, value);
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_and_small();
    test_signed_extremes();
    test_unsigned_extremes();
    test_hex_digits();
    test_unused_operation();
    test_random_numbers();

    // drop valid and let the last text drain
    in_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Formatted %0d numbers (signed %0d, unsigned %0d, hex %0d, unused code %0d)",
             numbers_sent, numbers_by_op[0], numbers_by_op[1], numbers_by_op[2],
             numbers_by_op[3]);
    $display("Compared %0d characters under random gaps and stalls, %0d mismatches",
             chars_checked, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ita_pkg.sv
rtl/core/ita_conv.sv
rtl/core/ita_emit.sv
rtl/core/integer_to_ascii_text_core.sv
tb/integer_to_ascii_text_core_test.sv
